// ----- design/assert_macros.svh -----
// Assertion macros for the port-level checker file.
// Each macro wraps one concurrent assertion with clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ZT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset
`define ZT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- design/zt_pkg.sv -----
// Package for the zone text tokenizer: payload structs, scan modes,
// character codes and the piece index helper. No dependencies.
`timescale 1ns / 1ps

package zt_pkg;

   // Piece count saturates here
   localparam int MAX_PIECES = 255;
   localparam int CNT_W      = $clog2(MAX_PIECES + 1);

   // Character codes
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_LPAR   = 8'h28;
   localparam logic [7:0] CHR_RPAR   = 8'h29;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_FF     = 8'h0C;
   localparam logic [7:0] CHR_VT     = 8'h0B;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      MODE_BETWEEN     = 3'd0,
      MODE_COMMENT     = 3'd1,
      MODE_UNQ         = 3'd2,
      MODE_UNQ_ESC     = 3'd3,
      MODE_QUO         = 3'd4,
      MODE_QUO_ESC     = 3'd5,
      MODE_AFTER_QUOTE = 3'd6
   } zt_mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } zt_req_type;

   typedef struct packed {
      logic        piece_byte;
      logic        piece_first;
      logic        piece_closed_before;
      logic [7:0]  piece_index;
      logic        owner_inherited;
      logic        record_done;
      logic        in_parens;
      logic [31:0] newlines_seen;
   } zt_rsp_type;

   typedef struct packed {
      zt_mode_type      mode;
      logic             paren_open;
      logic [CNT_W-1:0] pieces;
      logic             at_origin;
      logic [31:0]      line_breaks;
   } zt_state_type;

   localparam zt_state_type STATE_RESET = '{
      mode:        MODE_BETWEEN,
      paren_open:  1'b0,
      pieces:      '0,
      at_origin:   1'b1,
      line_breaks: 32'd0
   };

   // Index of the current piece: count minus one, capped at 255
   function automatic logic [7:0] piece_idx(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] dec;
      begin
         dec = cnt - CNT_W'(1);
         if (cnt == '0) begin
            return 8'd0;
         end else if (32'(dec) > 32'd255) begin
            return 8'hFF;
         end else begin
            return 8'(dec);
         end
      end
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_FF);
   endfunction

endpackage

// ----- design/zt_step.sv -----
// Combinational scan step: next tokenizer state and result for one byte.
// Depends on zt_pkg.
`timescale 1ns / 1ps

module zt_step import zt_pkg::*; (
   input  zt_state_type state_cur,
   input  zt_req_type   req,
   output zt_state_type state_nxt,
   output zt_rsp_type   rsp
);

   logic [7:0] b;
   logic       is_nl;
   logic       do_btw;
   logic       part;

   assign b     = req.text_byte;
   assign is_nl = (b == CHR_NL);

   always_comb begin
      state_nxt = state_cur;
      rsp       = '0;
      do_btw    = 1'b0;
      part      = 1'b0;

      if (req.end_of_text) begin
         // Flush: report open piece and record, then return to reset
         rsp.piece_closed_before = (state_cur.mode == MODE_UNQ) ||
                                   (state_cur.mode == MODE_UNQ_ESC) ||
                                   (state_cur.mode == MODE_QUO) ||
                                   (state_cur.mode == MODE_QUO_ESC) ||
                                   (state_cur.mode == MODE_AFTER_QUOTE);
         rsp.record_done   = (state_cur.pieces != '0);
         rsp.newlines_seen = state_cur.line_breaks;
         state_nxt         = STATE_RESET;
      end else begin
         // Count every newline byte
         state_nxt.line_breaks = state_cur.line_breaks + 32'(is_nl);

         case (state_cur.mode)
            MODE_COMMENT: begin
               if (is_nl) begin
                  do_btw = 1'b1;
               end else begin
                  state_nxt.at_origin = 1'b0;
               end
            end
            MODE_UNQ, MODE_UNQ_ESC: begin
               if ((state_cur.mode == MODE_UNQ_ESC) &&
                   (is_blank(b) || is_nl || (b == CHR_VT) || (b == CHR_CR))) begin
                  // Escaped blank stays in the piece
                  part                = 1'b1;
                  state_nxt.mode      = MODE_UNQ;
                  state_nxt.at_origin = 1'b0;
               end else if (is_nl || is_blank(b)) begin
                  rsp.piece_closed_before = 1'b1;
                  do_btw                  = 1'b1;
               end else if ((b == CHR_RPAR) && state_cur.paren_open) begin
                  rsp.piece_closed_before = 1'b1;
                  state_nxt.paren_open    = 1'b0;
                  state_nxt.mode          = MODE_BETWEEN;
                  state_nxt.at_origin     = 1'b0;
               end else begin
                  part                = 1'b1;
                  state_nxt.mode      = ((b == CHR_BSLASH) && !state_cur.paren_open) ?
                                        MODE_UNQ_ESC : MODE_UNQ;
                  state_nxt.at_origin = 1'b0;
               end
            end
            MODE_QUO, MODE_QUO_ESC: begin
               if ((state_cur.mode == MODE_QUO_ESC) &&
                   ((b == CHR_QUOTE) || (b == CHR_BSLASH))) begin
                  part                = 1'b1;
                  state_nxt.mode      = MODE_QUO;
                  state_nxt.at_origin = 1'b0;
               end else if (is_nl) begin
                  rsp.piece_closed_before = 1'b1;
                  do_btw                  = 1'b1;
               end else begin
                  part                = 1'b1;
                  state_nxt.at_origin = 1'b0;
                  if (b == CHR_QUOTE) begin
                     state_nxt.mode = MODE_AFTER_QUOTE;
                  end else if (b == CHR_BSLASH) begin
                     state_nxt.mode = MODE_QUO_ESC;
                  end else begin
                     state_nxt.mode = MODE_QUO;
                  end
               end
            end
            MODE_AFTER_QUOTE: begin
               rsp.piece_closed_before = 1'b1;
               do_btw                  = 1'b1;
            end
            default: begin
               do_btw = 1'b1;
            end
         endcase

         // Handle a byte seen while no piece is open
         if (do_btw) begin
            state_nxt.mode      = MODE_BETWEEN;
            state_nxt.at_origin = 1'b0;
            if (b == CHR_SEMI) begin
               state_nxt.mode = MODE_COMMENT;
            end else if (is_nl) begin
               if (!state_cur.paren_open) begin
                  rsp.record_done     = (state_cur.pieces != '0);
                  state_nxt.pieces    = '0;
                  state_nxt.at_origin = 1'b1;
               end
            end else if (is_blank(b)) begin
               // skip
            end else if ((b == CHR_LPAR) && !state_cur.paren_open) begin
               state_nxt.paren_open = 1'b1;
            end else if ((b == CHR_RPAR) && state_cur.paren_open) begin
               state_nxt.paren_open = 1'b0;
            end else begin
               // Open a new piece
               if (state_cur.pieces == '0) begin
                  rsp.owner_inherited = !state_cur.at_origin;
               end
               if (state_cur.pieces < CNT_W'(MAX_PIECES)) begin
                  state_nxt.pieces = state_cur.pieces + CNT_W'(1);
               end
               rsp.piece_first = 1'b1;
               part            = 1'b1;
               if (b == CHR_QUOTE) begin
                  state_nxt.mode = MODE_QUO;
               end else if ((b == CHR_BSLASH) && !state_cur.paren_open) begin
                  state_nxt.mode = MODE_UNQ_ESC;
               end else begin
                  state_nxt.mode = MODE_UNQ;
               end
            end
         end

         rsp.piece_byte    = part;
         rsp.piece_index   = part ? piece_idx(state_nxt.pieces) : 8'd0;
         rsp.in_parens     = state_nxt.paren_open;
         rsp.newlines_seen = state_nxt.line_breaks;
      end
   end

endmodule

// ----- design/zone_text_tokenizer_top.sv -----
// Zone text tokenizer: byte-wide lexer for DNS master file text.
// Channels: req (one text byte or end-of-text flush per transfer) and
// rsp (one result per accepted item, in order).
// Operation:
//   - An accepted item lands in the input register, is scanned there
//     against the tokenizer state, and the result lands in the output
//     register once that register is free.
//   - Throughput is one item per cycle unless the receiver stalls. Scanning
//     a byte is a short mode update between the input and output registers,
//     and the state registers advance as each item moves into the output register.
//   - When the receiver stalls, the result holds in the output register,
//     one more item waits in the input register, and then req_ready drops.
//   - Reset clears both stage valids and returns the scan state to between
//     pieces, no open parenthesis, empty record and zero newline count.
//   - An end-of-text flush reports the close of an open piece and record,
//     then returns the scan state to its reset value.
// Depends on zt_pkg and zt_step.
`timescale 1ns / 1ps

module zone_text_tokenizer_top import zt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  zt_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output zt_rsp_type rsp_data
);

   logic         in_valid_ff;
   logic         in_valid_in;
   zt_req_type   in_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   zt_rsp_type   out_data_ff;
   zt_state_type state_ff;
   zt_state_type state_in;
   zt_rsp_type   step_rsp;
   logic         advance;

   // Move the input item forward when the output register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   zt_step u_step (
      .state_cur (state_ff),
      .req       (in_data_ff),
      .state_nxt (state_in),
      .rsp       (step_rsp)
   );

   // Control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- design/zt_checker.sv -----
// Port-level checker for the zone text tokenizer, bound to the top level.
// Depends on zt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zt_checker import zt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input zt_rsp_type rsp_data
);

   // Stalled result holds
   `ZT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A piece start is always a piece byte
   `ZT_ASSERT_IMPLY(a_first_is_byte, clock, reset, rsp_valid && rsp_data.piece_first, rsp_data.piece_byte)

   // Owner inheritance is reported only on a piece start
   `ZT_ASSERT_IMPLY(a_inherit_first, clock, reset, rsp_valid && rsp_data.owner_inherited, rsp_data.piece_first)

   // A record never ends inside parentheses
   `ZT_ASSERT_IMPLY(a_done_no_paren, clock, reset, rsp_valid && rsp_data.record_done, !rsp_data.in_parens)

endmodule

bind zone_text_tokenizer_top zt_checker u_zt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- test/zt_scan_checker.sv -----
// Checker for the zone text tokenizer: tracks the scan state of the text it
// sees accepted and compares every result transfer against its prediction.
// Depends on zt_pkg for the payload structs, scan modes and character codes.
`timescale 1ns / 1ps

module zt_scan_checker import zt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  zt_req_type req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  zt_rsp_type rsp_data,
   output int         mismatch_count,
   output int         pending_count
);

   // Predicted scan state
   zt_mode_type scan_st;
   logic        paren_q;
   int unsigned piece_cnt;
   logic        origin_q;
   logic [31:0] nl_cnt;

   // Predicted results still waiting for their transfer
   zt_rsp_type  pending_scans[$];

   task automatic clear_scan();
      scan_st   = MODE_BETWEEN;
      paren_q   = 1'b0;
      piece_cnt = 0;
      origin_q  = 1'b1;
      nl_cnt    = 32'd0;
   endtask

   function automatic logic blank_chr(input logic [7:0] b);
      return (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_FF);
   endfunction

   // Index of the open piece, capped at 255
   function automatic logic [7:0] cur_idx();
      if (piece_cnt == 0) begin
         return 8'd0;
      end
      return (piece_cnt - 1 > 255) ? 8'hFF : 8'(piece_cnt - 1);
   endfunction

   task automatic mark_piece(inout zt_rsp_type r);
      r.piece_byte  = 1'b1;
      r.piece_index = cur_idx();
   endtask

   // Byte seen while no piece is open
   task automatic open_gap(input logic [7:0] b, inout zt_rsp_type r);
      logic record_end;
      record_end = 1'b0;
      scan_st = MODE_BETWEEN;
      if (b == CHR_SEMI) begin
         scan_st = MODE_COMMENT;
      end else if (b == CHR_NL) begin
         // inside parentheses a newline is only blank space
         if (!paren_q) begin
            r.record_done = (piece_cnt != 0);
            piece_cnt     = 0;
            origin_q      = 1'b1;
            record_end    = 1'b1;
         end
      end else if (blank_chr(b)) begin
         // skip separator
      end else if (b == CHR_LPAR && !paren_q) begin
         paren_q = 1'b1;
      end else if (b == CHR_RPAR && paren_q) begin
         paren_q = 1'b0;
      end else begin
         // open a new piece; owner inheritance only on the record's first
         if (piece_cnt == 0) begin
            r.owner_inherited = !origin_q;
         end
         if (piece_cnt < MAX_PIECES) begin
            piece_cnt++;
         end
         r.piece_first = 1'b1;
         mark_piece(r);
         if (b == CHR_QUOTE) begin
            scan_st = MODE_QUO;
         end else if (b == CHR_BSLASH && !paren_q) begin
            scan_st = MODE_UNQ_ESC;
         end else begin
            scan_st = MODE_UNQ;
         end
      end
      if (!record_end) begin
         origin_q = 1'b0;
      end
   endtask

   task automatic unquoted_byte(input logic [7:0] b, inout zt_rsp_type r);
      if (b == CHR_NL || blank_chr(b)) begin
         r.piece_closed_before = 1'b1;
         open_gap(b, r);
      end else if (b == CHR_RPAR && paren_q) begin
         r.piece_closed_before = 1'b1;
         paren_q  = 1'b0;
         scan_st  = MODE_BETWEEN;
         origin_q = 1'b0;
      end else begin
         mark_piece(r);
         scan_st  = (b == CHR_BSLASH && !paren_q) ? MODE_UNQ_ESC : MODE_UNQ;
         origin_q = 1'b0;
      end
   endtask

   task automatic quoted_byte(input logic [7:0] b, inout zt_rsp_type r);
      if (b == CHR_NL) begin
         r.piece_closed_before = 1'b1;
         open_gap(b, r);
      end else begin
         mark_piece(r);
         if (b == CHR_QUOTE) begin
            scan_st = MODE_AFTER_QUOTE;
         end else if (b == CHR_BSLASH) begin
            scan_st = MODE_QUO_ESC;
         end else begin
            scan_st = MODE_QUO;
         end
         origin_q = 1'b0;
      end
   endtask

   // Advance the predicted scan by one accepted item
   task automatic scan_predict(input zt_req_type item, output zt_rsp_type r);
      logic [7:0] b;
      b = item.text_byte;
      r = '0;
      if (item.end_of_text) begin
         // flush: report close and record end, then start over
         r.piece_closed_before = (scan_st != MODE_BETWEEN) && (scan_st != MODE_COMMENT);
         r.record_done         = (piece_cnt != 0);
         r.newlines_seen       = nl_cnt;
         clear_scan();
      end else begin
         if (b == CHR_NL) begin
            nl_cnt = nl_cnt + 32'd1;
         end
         case (scan_st)
            MODE_COMMENT: begin
               if (b == CHR_NL) begin
                  open_gap(b, r);
               end else begin
                  origin_q = 1'b0;
               end
            end
            MODE_UNQ: begin
               unquoted_byte(b, r);
            end
            MODE_UNQ_ESC: begin
               if (blank_chr(b) || b == CHR_NL || b == CHR_VT || b == CHR_CR) begin
                  mark_piece(r);
                  scan_st  = MODE_UNQ;
                  origin_q = 1'b0;
               end else begin
                  unquoted_byte(b, r);
               end
            end
            MODE_QUO: begin
               quoted_byte(b, r);
            end
            MODE_QUO_ESC: begin
               if (b == CHR_QUOTE || b == CHR_BSLASH) begin
                  mark_piece(r);
                  scan_st  = MODE_QUO;
                  origin_q = 1'b0;
               end else begin
                  quoted_byte(b, r);
               end
            end
            MODE_AFTER_QUOTE: begin
               r.piece_closed_before = 1'b1;
               open_gap(b, r);
            end
            default: begin
               open_gap(b, r);
            end
         endcase
         r.in_parens     = paren_q;
         r.newlines_seen = nl_cnt;
      end
   endtask

   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Compare result transfers first, then predict newly accepted bytes
   always @(posedge clock) begin
      zt_rsp_type want;
      zt_rsp_type next_rsp;
      if (reset) begin
         clear_scan();
         pending_scans.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_scans.size() == 0) begin
               $error("result transfer with no prediction pending");
               mismatch_count++;
            end else begin
               want = pending_scans.pop_front();
               mismatch_count += field_diff("piece_byte", 32'(want.piece_byte),
                                            32'(rsp_data.piece_byte));
               mismatch_count += field_diff("piece_first", 32'(want.piece_first),
                                            32'(rsp_data.piece_first));
               mismatch_count += field_diff("piece_closed_before",
                                            32'(want.piece_closed_before),
                                            32'(rsp_data.piece_closed_before));
               mismatch_count += field_diff("piece_index", 32'(want.piece_index),
                                            32'(rsp_data.piece_index));
               mismatch_count += field_diff("owner_inherited",
                                            32'(want.owner_inherited),
                                            32'(rsp_data.owner_inherited));
               mismatch_count += field_diff("record_done", 32'(want.record_done),
                                            32'(rsp_data.record_done));
               mismatch_count += field_diff("in_parens", 32'(want.in_parens),
                                            32'(rsp_data.in_parens));
               mismatch_count += field_diff("newlines_seen", want.newlines_seen,
                                            rsp_data.newlines_seen);
            end
         end
         if (req_valid && req_ready) begin
            scan_predict(req_data, next_rsp);
            pending_scans.push_back(next_rsp);
         end
      end
      pending_count <= pending_scans.size();
   end

endmodule

// ----- test/tb_top.sv -----
// Top of the zone text tokenizer testbench: clock, reset, text stimulus,
// receiver stalls, watchdog and verdict. Depends on zt_pkg, the tokenizer
// top and zt_scan_checker.
`timescale 1ns / 1ps

module tb_top import zt_pkg::*; ();

   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int HOLD_CYCLES    = 400;
   localparam int STALL_LIMIT    = 2000;
   localparam int CAP_PIECES     = MAX_PIECES + 5;

   localparam logic [7:0] CHR_A    = 8'h61;
   localparam logic [7:0] CHR_DIG0 = 8'h30;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   zt_req_type req_data  = '0;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   zt_rsp_type rsp_data;
   int         mismatches;
   int         pending;

   // Idle pattern state, one pair per side
   int         req_run   = 0;
   bit         req_quiet = 1'b0;
   int         rsp_run   = 0;
   bit         rsp_quiet = 1'b0;
   logic       rsp_hold_ask = 1'b0;

   int         sent_items = 0;
   int         text_bytes = 0;
   int         flushes    = 0;
   int         idle_cycles = 0;

   zone_text_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   zt_scan_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw a wait per item; alternate busy stretches with zero-wait stretches
   task automatic pick_gap(inout int run_left, inout bit quiet, output int gap);
      if (run_left == 0) begin
         quiet    = ($urandom_range(0, 3) == 0);
         run_left = $urandom_range(10, 60);
      end
      run_left--;
      gap = quiet ? 0 : $urandom_range(0, 18);
   endtask

   task automatic send_item(input zt_req_type item);
      int gap;
      pick_gap(req_run, req_quiet, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      if (item.end_of_text) begin
         flushes++;
      end else begin
         text_bytes++;
      end
   endtask

   task automatic put_byte(input logic [7:0] b);
      send_item('{text_byte: b, end_of_text: 1'b0});
   endtask

   task automatic put_flush();
      send_item('{text_byte: 8'($urandom_range(0, 255)), end_of_text: 1'b1});
   endtask

   // Stop offering and wait for every predicted result to arrive
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] letter();
      return CHR_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 11))
         7:       return CHR_DIG0 + 8'($urandom_range(0, 9));
         8:       return 8'($urandom_range(128, 255));
         9:       return $urandom_range(0, 1) ? CHR_LPAR : CHR_RPAR;
         10:      return CHR_QUOTE;
         11:      return CHR_SEMI;
         default: return letter();
      endcase
   endfunction

   function automatic logic [7:0] esc_target();
      case ($urandom_range(0, 7))
         0:       return CHR_SPACE;
         1:       return CHR_TAB;
         2:       return CHR_NL;
         3:       return CHR_VT;
         4:       return CHR_FF;
         5:       return CHR_CR;
         6:       return CHR_BSLASH;
         default: return letter();
      endcase
   endfunction

   task automatic gen_blank();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0:       put_byte(CHR_TAB);
            1:       put_byte(CHR_FF);
            default: put_byte(CHR_SPACE);
         endcase
      end
   endtask

   // Comment text up to, but not including, the newline
   task automatic gen_comment();
      int         n;
      logic [7:0] b;
      put_byte(CHR_SEMI);
      n = $urandom_range(0, 5);
      repeat (n) begin
         b = 8'($urandom_range(0, 255));
         put_byte((b == CHR_NL) ? CHR_SPACE : b);
      end
   endtask

   task automatic gen_word();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            put_byte(CHR_BSLASH);
            put_byte(esc_target());
         end else begin
            put_byte((i == 0) ? letter() : word_char());
         end
      end
   endtask

   task automatic gen_quoted();
      int n;
      put_byte(CHR_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
         case ($urandom_range(0, 11))
            0: begin
               put_byte(CHR_BSLASH);
               case ($urandom_range(0, 2))
                  0:       put_byte(CHR_QUOTE);
                  1:       put_byte(CHR_BSLASH);
                  default: put_byte(letter());
               endcase
            end
            1:       put_byte($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB);
            2:       put_byte($urandom_range(0, 1) ? CHR_SEMI : CHR_LPAR);
            3:       put_byte(($urandom_range(0, 3) == 0) ? CHR_NL : letter());
            default: put_byte(letter());
         endcase
      end
      if ($urandom_range(0, 9) != 0) begin
         put_byte(CHR_QUOTE);
      end
   endtask

   // One record: optional leading blank, pieces, parentheses, comment, end
   task automatic gen_record();
      int np;
      bit in_paren;
      bit last_quoted;
      in_paren    = 1'b0;
      last_quoted = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
         gen_blank();
      end
      np = $urandom_range(1, 6);
      for (int k = 0; k < np; k++) begin
         if (k > 0 && !(last_quoted && $urandom_range(0, 3) == 0)) begin
            gen_blank();
         end
         if (!in_paren && $urandom_range(0, 7) == 0) begin
            put_byte(CHR_LPAR);
            in_paren = 1'b1;
         end else if (in_paren && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) begin
               gen_comment();
            end
            put_byte(CHR_NL);
         end
         last_quoted = ($urandom_range(0, 3) == 0);
         if (last_quoted) begin
            gen_quoted();
         end else begin
            gen_word();
         end
         if (in_paren && $urandom_range(0, 2) == 0) begin
            put_byte(CHR_RPAR);
            in_paren = 1'b0;
         end
      end
      if (in_paren) begin
         gen_blank();
         put_byte(CHR_RPAR);
      end
      if ($urandom_range(0, 3) == 0) begin
         gen_blank();
         gen_comment();
      end
      if ($urandom_range(0, 19) == 0) begin
         put_flush();
      end else begin
         put_byte(CHR_NL);
      end
   endtask

   // Receiver: random waits per result, one long hold-off on request
   initial begin
      int  gap;
      bit  hold_served;
      hold_served = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         pick_gap(rsp_run, rsp_quiet, gap);
         if (rsp_hold_ask && !hold_served) begin
            hold_served = 1'b1;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int pick;
      bit cap_done;
      bit hold_asked;
      bit drained;
      cap_done   = 1'b0;
      hold_asked = 1'b0;
      drained    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // leading blank, byte extremes, escaped space in an unquoted piece
      put_byte(CHR_SPACE);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(CHR_SPACE);
      put_byte(CHR_BSLASH);
      put_byte(CHR_SPACE);
      put_byte(CHR_TAB);
      // quoted escape, then a newline inside the quotes, then an empty line
      put_byte(CHR_QUOTE);
      put_byte(CHR_BSLASH);
      put_byte(CHR_QUOTE);
      put_byte(CHR_NL);
      put_byte(CHR_NL);
      // parentheses at record start, stray open inside, newline as blank
      put_byte(CHR_LPAR);
      put_byte(CHR_LPAR);
      put_byte(CHR_NL);
      put_byte(CHR_RPAR);
      // stray close outside parentheses, quote inside an unquoted piece
      put_byte(CHR_RPAR);
      put_byte(CHR_QUOTE);
      put_byte(CHR_FF);
      // piece right after a closing quote, flushed while still open
      put_byte(CHR_QUOTE);
      put_byte(CHR_QUOTE);
      put_byte(CHR_A + 8'd1);
      put_flush();
      // comment-only line
      put_byte(CHR_SEMI);
      put_byte(CHR_NL);

      while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         // one record past the piece cap, from a clean scan state
         if (!cap_done && sent_items > DIRECTED_ITEMS + 150) begin
            cap_done = 1'b1;
            put_flush();
            for (int i = 0; i < CAP_PIECES; i++) begin
               put_byte(letter());
               put_byte(CHR_SPACE);
            end
            put_byte(CHR_NL);
         end
         // long receiver hold while the sender keeps offering
         if (!hold_asked && sent_items > DIRECTED_ITEMS + RANDOM_ITEMS / 3) begin
            hold_asked = 1'b1;
            rsp_hold_ask <= 1'b1;
         end
         if (!drained && sent_items > DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) begin
            drained = 1'b1;
            drain_results();
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            gen_record();
         end else if (pick < 85) begin
            if ($urandom_range(0, 1)) begin
               gen_blank();
            end
            if ($urandom_range(0, 1)) begin
               gen_comment();
            end
            put_byte(CHR_NL);
         end else if (pick < 96) begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
         end else begin
            put_flush();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Sent %0d text bytes and %0d flushes: records, quotes, escapes, comments,",
               text_bytes, flushes);
      $display("parentheses, noise, one record past the piece cap, a %0d-cycle stall.",
               HOLD_CYCLES);
      if (mismatches == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
